// ===== hdl/hcls_pkg.sv =====
// ----------------------------------------------------------------------------
// hcls_pkg: shared definitions for the content-length scanner
// Holds the length width, status codes, the result record, character
// constants and the two header-name prefixes.
// ----------------------------------------------------------------------------
package hcls_pkg;

    // Width of the parsed body length.
    localparam int LENGTH_WIDTH = 64;

    // Largest length value and the highest accumulator value that still
    // accepts one more decimal digit.
    localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX  = '1;
    localparam logic [LENGTH_WIDTH-1:0] DIGIT_LIMIT = (LENGTH_MAX - LENGTH_WIDTH'(9)) /
                                                      LENGTH_WIDTH'(10);

    // Prefix lengths.
    localparam int TE_LEN = 17;
    localparam int CL_LEN = 15;

    // Characters of interest.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_FOUND   = 2'd1,
        ST_REFUSED = 2'd2
    } status_t;

    // One result item.
    typedef struct packed {
        logic [LENGTH_WIDTH-1:0] length;
        status_t                 status;
    } result_t;

    // Character of "transfer-encoding" at a position; zero past its end.
    function automatic logic [7:0] te_char(input logic [4:0] pos);
        logic [7:0] ch;
        case (pos)
            5'd0:    ch = "t";
            5'd1:    ch = "r";
            5'd2:    ch = "a";
            5'd3:    ch = "n";
            5'd4:    ch = "s";
            5'd5:    ch = "f";
            5'd6:    ch = "e";
            5'd7:    ch = "r";
            5'd8:    ch = "-";
            5'd9:    ch = "e";
            5'd10:   ch = "n";
            5'd11:   ch = "c";
            5'd12:   ch = "o";
            5'd13:   ch = "d";
            5'd14:   ch = "i";
            5'd15:   ch = "n";
            5'd16:   ch = "g";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Character of "content-length:" at a position; zero past its end.
    function automatic logic [7:0] cl_char(input logic [4:0] pos);
        logic [7:0] ch;
        case (pos)
            5'd0:    ch = "c";
            5'd1:    ch = "o";
            5'd2:    ch = "n";
            5'd3:    ch = "t";
            5'd4:    ch = "e";
            5'd5:    ch = "n";
            5'd6:    ch = "t";
            5'd7:    ch = "-";
            5'd8:    ch = "l";
            5'd9:    ch = "e";
            5'd10:   ch = "n";
            5'd11:   ch = "g";
            5'd12:   ch = "t";
            5'd13:   ch = "h";
            5'd14:   ch = ":";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hdl/hcls_core.sv =====
// ----------------------------------------------------------------------------
// hcls_core: per-byte header scanner
// Holds the line and value state and updates it from one head byte per
// enabled cycle. On the last byte it presents the result and starts over.
// ----------------------------------------------------------------------------
module hcls_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,     // one byte is processed this cycle
    input  logic [7:0]          head_byte,
    input  logic                last_byte,
    output logic                result_valid,
    output hcls_pkg::result_t   result
);

    // Position within the current line.
    typedef enum logic [2:0] {
        PH_REQLINE,
        PH_MATCH,
        PH_VALUE,
        PH_TRAIL,
        PH_IGNORE
    } phase_t;

    phase_t                            phase_reg, phase_next;
    logic [4:0]                        pos_reg, pos_next;
    logic                              te_alive_reg, te_alive_next;
    logic                              cl_alive_reg, cl_alive_next;
    logic                              digits_reg, digits_next;
    logic [hcls_pkg::LENGTH_WIDTH-1:0] acc_reg, acc_next;
    logic                              seen_reg, seen_next;
    logic [hcls_pkg::LENGTH_WIDTH-1:0] stored_reg, stored_next;
    logic                              refused_reg, refused_next;

    logic [7:0]                        lower_byte;
    logic                              is_digit;
    logic                              is_blank;
    logic [hcls_pkg::LENGTH_WIDTH-1:0] acc_times_ten;
    logic                              close_refuse;
    logic                              close_store;
    logic                              end_refuse;
    logic                              end_store;

    // Byte classification and the multiply-add by ten.
    assign lower_byte = (head_byte >= hcls_pkg::CH_UPA && head_byte <= hcls_pkg::CH_UPZ) ?
                        head_byte + hcls_pkg::CASE_OFS : head_byte;
    assign is_digit   = head_byte >= hcls_pkg::CH_ZERO && head_byte <= hcls_pkg::CH_NINE;
    assign is_blank   = head_byte == hcls_pkg::CH_SPACE || head_byte == hcls_pkg::CH_TAB;
    assign acc_times_ten = (acc_reg << 3) + (acc_reg << 1);

    // Judgement of a value line that ends at this LF.
    assign close_refuse = (phase_reg == PH_VALUE && !digits_reg) ||
                          ((phase_reg == PH_VALUE || phase_reg == PH_TRAIL) &&
                           seen_reg && acc_reg != stored_reg);
    assign close_store  = (phase_reg == PH_VALUE || phase_reg == PH_TRAIL) && !close_refuse;

    // Next state for one byte, then the end-of-head close and restart.
    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        te_alive_next = te_alive_reg;
        cl_alive_next = cl_alive_reg;
        digits_next   = digits_reg;
        acc_next      = acc_reg;
        seen_next     = seen_reg;
        stored_next   = stored_reg;
        refused_next  = refused_reg;
        end_refuse    = 1'b0;
        end_store     = 1'b0;
        result_valid  = 1'b0;
        result        = '{length: '0, status: hcls_pkg::ST_NONE};

        if (refused_reg) begin
            // A refused head ignores everything up to its last byte.
        end else if (phase_reg == PH_REQLINE) begin
            if (head_byte == hcls_pkg::CH_LF) begin
                phase_next    = PH_MATCH;
                pos_next      = '0;
                te_alive_next = 1'b1;
                cl_alive_next = 1'b1;
                digits_next   = 1'b0;
                acc_next      = '0;
            end
        end else if (head_byte == hcls_pkg::CH_LF) begin
            if (close_refuse) begin
                refused_next = 1'b1;
            end else begin
                if (close_store) begin
                    stored_next = acc_reg;
                    seen_next   = 1'b1;
                end
                phase_next    = PH_MATCH;
                pos_next      = '0;
                te_alive_next = 1'b1;
                cl_alive_next = 1'b1;
                digits_next   = 1'b0;
                acc_next      = '0;
            end
        end else begin
            case (phase_reg)
                PH_MATCH: begin
                    te_alive_next = te_alive_reg && pos_reg < 5'(hcls_pkg::TE_LEN) &&
                                    lower_byte == hcls_pkg::te_char(pos_reg);
                    cl_alive_next = cl_alive_reg && pos_reg < 5'(hcls_pkg::CL_LEN) &&
                                    lower_byte == hcls_pkg::cl_char(pos_reg);
                    pos_next      = pos_reg + 5'd1;
                    if (te_alive_next && pos_next == 5'(hcls_pkg::TE_LEN)) begin
                        refused_next = 1'b1;
                    end else if (cl_alive_next && pos_next == 5'(hcls_pkg::CL_LEN)) begin
                        phase_next  = PH_VALUE;
                        digits_next = 1'b0;
                        acc_next    = '0;
                    end else if (!te_alive_next && !cl_alive_next) begin
                        phase_next = PH_IGNORE;
                    end
                end
                PH_VALUE: begin
                    if (is_digit) begin
                        if (acc_reg > hcls_pkg::DIGIT_LIMIT) begin
                            refused_next = 1'b1;
                        end else begin
                            acc_next    = acc_times_ten +
                                          hcls_pkg::LENGTH_WIDTH'(head_byte[3:0]);
                            digits_next = 1'b1;
                        end
                    end else if (is_blank) begin
                        if (digits_reg) begin
                            phase_next = PH_TRAIL;
                        end
                    end else if (head_byte == hcls_pkg::CH_CR && digits_reg) begin
                        phase_next = PH_TRAIL;
                    end else begin
                        refused_next = 1'b1;
                    end
                end
                PH_TRAIL: begin
                    if (!is_blank && head_byte != hcls_pkg::CH_CR) begin
                        refused_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (last_byte) begin
            // The last byte also ends the line that is open.
            if (!refused_next && phase_next != PH_REQLINE) begin
                end_refuse = (phase_next == PH_VALUE && !digits_next) ||
                             ((phase_next == PH_VALUE || phase_next == PH_TRAIL) &&
                              seen_next && acc_next != stored_next);
                end_store  = (phase_next == PH_VALUE || phase_next == PH_TRAIL) &&
                             !end_refuse;
            end
            result_valid = step_en;
            if (refused_next || end_refuse) begin
                result.status = hcls_pkg::ST_REFUSED;
            end else if (end_store) begin
                result.status = hcls_pkg::ST_FOUND;
                result.length = acc_next;
            end else if (seen_next) begin
                result.status = hcls_pkg::ST_FOUND;
                result.length = stored_next;
            end

            // Back to the start state for the next head.
            phase_next    = PH_REQLINE;
            pos_next      = '0;
            te_alive_next = 1'b0;
            cl_alive_next = 1'b0;
            digits_next   = 1'b0;
            acc_next      = '0;
            seen_next     = 1'b0;
            stored_next   = '0;
            refused_next  = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_REQLINE;
            pos_reg      <= '0;
            te_alive_reg <= 1'b0;
            cl_alive_reg <= 1'b0;
            digits_reg   <= 1'b0;
            acc_reg      <= '0;
            seen_reg     <= 1'b0;
            stored_reg   <= '0;
            refused_reg  <= 1'b0;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            te_alive_reg <= te_alive_next;
            cl_alive_reg <= cl_alive_next;
            digits_reg   <= digits_next;
            acc_reg      <= acc_next;
            seen_reg     <= seen_next;
            stored_reg   <= stored_next;
            refused_reg  <= refused_next;
        end
    end

endmodule

// ===== hdl/http_content_length_scanner.sv =====
// ----------------------------------------------------------------------------
// http_content_length_scanner: HTTP head Content-Length scanner
// Scans request head bytes and reports the announced body length.
// ----------------------------------------------------------------------------
// The block takes one head byte per cycle on the slave stream, with tlast on
// the final byte of the head, and returns one result per head on the master
// stream: a status (none, found, refused) and the 64-bit length. A byte is
// registered when it is transferred and processed from the input register;
// a last byte's result is then registered in the output register. Bytes keep
// flowing at one per cycle; only a last byte waits while an earlier result is
// still held in the output register. The per-byte path is the multiply-add by
// ten of the length accumulator and the compare against the first length.
module http_content_length_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] head_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [1:0] length_status, [65:2] content_length, zero pad
);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic                step_fire;
    logic                core_valid;
    hcls_pkg::result_t   core_result;
    logic                out_valid_reg;
    hcls_pkg::result_t   out_result_reg;

    // A byte is processed unless it is a last byte and the result slot is full and not being emptied.
    assign step_fire = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step_fire;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (step_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    hcls_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_fire),
        .head_byte    (in_byte_reg),
        .last_byte    (in_last_reg),
        .result_valid (core_valid),
        .result       (core_result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (core_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_valid) begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_result_reg.length, out_result_reg.status};

    // A processed last byte always leaves a result in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && in_last_reg |=> out_valid_reg)
        else $error("result missing after last byte");

    // The status code is never the unused value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'b11)
        else $error("invalid status code");

    // Only a found length carries a nonzero length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != hcls_pkg::ST_FOUND |-> m_tdata[65:2] == '0)
        else $error("length set without found status");

    // A held byte is only ever a last byte waiting for the result slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !step_fire |-> in_last_reg && out_valid_reg)
        else $error("input stage stalled without cause");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for http_content_length_scanner
// Streams request heads into the scanner one byte per transfer and checks
// every result against its pinned expectation or a behavioral predictor that runs alongside the DUT.
// A table of directed heads covers the edge cases first. Random heads
// follow; most are well formed with random content, and some carry noise
// or broken length values. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int RANDOM_BYTES  = 460;
    localparam int RANDOM_HEADS  = 10;
    localparam int TAIL_CYCLES   = 8;
    localparam int N_CASES       = 21;

    // Clock, reset and DUT ports.
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] head_byte
    logic        s_tlast  = 1'b0;    // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;            // [1:0] length_status, [65:2] content_length, zero pad

    http_content_length_scanner dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 8 ns clock period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: tracks the line being scanned and the length so far.
    // ------------------------------------------------------------------------
    typedef enum logic [2:0] {
        LN_REQUEST,
        LN_NAME,
        LN_VALUE,
        LN_TRAIL,
        LN_SKIP
    } line_state_t;

    line_state_t ln_state   = LN_REQUEST;
    logic [4:0]  name_pos   = '0;
    bit          te_live    = 1'b0;
    bit          cl_live    = 1'b0;
    bit          have_digit = 1'b0;
    logic [63:0] accum      = '0;
    bit          len_valid  = 1'b0;
    logic [63:0] first_len  = '0;
    bit          refused    = 1'b0;

    string te_name = "transfer-encoding";
    string cl_name = "content-length:";

    // Results still owed by the DUT, oldest first.
    hcls_pkg::result_t length_reports_due[$];
    int                error_count = 0;

    // Bytes of the head being sent and its random generation state.
    logic [7:0] head_q[$];
    string      prev_digits;
    int         burst_left = 0;

    function automatic void clear_scan();
        ln_state   = LN_REQUEST;
        name_pos   = '0;
        te_live    = 1'b0;
        cl_live    = 1'b0;
        have_digit = 1'b0;
        accum      = '0;
        len_valid  = 1'b0;
        first_len  = '0;
        refused    = 1'b0;
    endfunction

    function automatic void open_header_line();
        ln_state   = LN_NAME;
        name_pos   = '0;
        te_live    = 1'b1;
        cl_live    = 1'b1;
        have_digit = 1'b0;
        accum      = '0;
    endfunction

    // A value line is judged when its line ends.
    function automatic void close_header_line();
        if (ln_state == LN_VALUE && !have_digit) begin
            refused = 1'b1;
        end else if (ln_state == LN_VALUE || ln_state == LN_TRAIL) begin
            if (len_valid && accum != first_len) begin
                refused = 1'b1;
            end else begin
                first_len = accum;
                len_valid = 1'b1;
            end
        end
    endfunction

    function automatic void scan_byte(input logic [7:0] b);
        logic [7:0] lc;
        if (refused) return;
        if (ln_state == LN_REQUEST) begin
            if (b == hcls_pkg::CH_LF) open_header_line();
            return;
        end
        if (b == hcls_pkg::CH_LF) begin
            close_header_line();
            if (!refused) open_header_line();
            return;
        end
        case (ln_state)
            LN_NAME: begin
                // Case-insensitive prefix match on both header names at once.
                lc = (b >= hcls_pkg::CH_UPA && b <= hcls_pkg::CH_UPZ) ?
                     b + hcls_pkg::CASE_OFS : b;
                te_live  = te_live && name_pos < hcls_pkg::TE_LEN &&
                           lc == te_name[name_pos];
                cl_live  = cl_live && name_pos < hcls_pkg::CL_LEN &&
                           lc == cl_name[name_pos];
                name_pos = name_pos + 5'd1;
                if (te_live && name_pos == hcls_pkg::TE_LEN) begin
                    refused = 1'b1;
                end else if (cl_live && name_pos == hcls_pkg::CL_LEN) begin
                    ln_state   = LN_VALUE;
                    have_digit = 1'b0;
                    accum      = '0;
                end else if (!te_live && !cl_live) begin
                    ln_state = LN_SKIP;
                end
            end
            LN_VALUE: begin
                if (b >= hcls_pkg::CH_ZERO && b <= hcls_pkg::CH_NINE) begin
                    if (accum > hcls_pkg::DIGIT_LIMIT) begin
                        refused = 1'b1;
                    end else begin
                        accum      = accum * 64'd10 + 64'(b - hcls_pkg::CH_ZERO);
                        have_digit = 1'b1;
                    end
                end else if (b == hcls_pkg::CH_SPACE || b == hcls_pkg::CH_TAB) begin
                    if (have_digit) ln_state = LN_TRAIL;
                end else if (b == hcls_pkg::CH_CR && have_digit) begin
                    ln_state = LN_TRAIL;
                end else begin
                    refused = 1'b1;
                end
            end
            LN_TRAIL: begin
                if (b != hcls_pkg::CH_SPACE && b != hcls_pkg::CH_TAB &&
                    b != hcls_pkg::CH_CR) refused = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Advances the predictor by one byte; returns 1 with the result on the
    // last byte of a head.
    function automatic bit track_head_byte(input logic [7:0] b, input bit last,
                                           output hcls_pkg::result_t res);
        res = '0;
        scan_byte(b);
        if (!last) return 1'b0;
        if (!refused && ln_state != LN_REQUEST) close_header_line();
        if (refused) begin
            res.status = hcls_pkg::ST_REFUSED;
        end else if (len_valid) begin
            res.status = hcls_pkg::ST_FOUND;
            res.length = first_len;
        end else begin
            res.status = hcls_pkg::ST_NONE;
        end
        clear_scan();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Directed heads. A tilde stands for byte 0xFF and \015 is a carriage
    // return. Rows with pinned set carry their expected result; the others
    // are checked against the predictor.
    // ------------------------------------------------------------------------
    typedef struct {
        string             text;
        bit                pinned;
        hcls_pkg::status_t status;
        logic [63:0]       length;
    } head_case_t;

    head_case_t head_cases [N_CASES] = '{
        '{"GET / HTTP/1.1", 1'b1, hcls_pkg::ST_NONE, 64'd0},
        '{"\n", 1'b1, hcls_pkg::ST_NONE, 64'd0},
        '{"G\nContent-Length: 42\015\n\015\n", 1'b1, hcls_pkg::ST_FOUND, 64'd42},
        '{"G\ncontent-length:18446744073709551609\n", 1'b1, hcls_pkg::ST_FOUND,
          64'd18446744073709551609},
        '{"G\nCONTENT-LENGTH:\t 184467440737095516090\015\n", 1'b1,
          hcls_pkg::ST_REFUSED, 64'd0},
        '{"G\nTransfer-Encoding: chunked\015\ncontent-length: 5\015\n", 1'b1,
          hcls_pkg::ST_REFUSED, 64'd0},
        '{"G\ntransfer-encodin\ncontent-length: 0", 1'b1, hcls_pkg::ST_FOUND, 64'd0},
        '{"G\ncontent-length: 7\015\nContent-Length:7 \t\015\n", 1'b1,
          hcls_pkg::ST_FOUND, 64'd7},
        '{"G\ncontent-length: 7\ncontent-length: 8\n", 1'b1, hcls_pkg::ST_REFUSED,
          64'd0},
        '{"G\ncontent-length: \015\n", 1'b1, hcls_pkg::ST_REFUSED, 64'd0},
        '{"G\ncontent-length:\n\n", 1'b1, hcls_pkg::ST_REFUSED, 64'd0},
        '{"G\ncontent-length: 12x\n", 1'b1, hcls_pkg::ST_REFUSED, 64'd0},
        '{"G\ncontent-length: 1 2\n", 1'b1, hcls_pkg::ST_REFUSED, 64'd0},
        '{"content-length: 9\nhost: a\n", 1'b1, hcls_pkg::ST_NONE, 64'd0},
        '{"G\ncontent-length 9\n~ontent-length: 9\n", 1'b1, hcls_pkg::ST_NONE, 64'd0},
        '{"G\nX: 1\015\ncontent-length:  00031\t\015\015 \n\015\n", 1'b1,
          hcls_pkg::ST_FOUND, 64'd31},
        '{"G\015\nhost: a\015\ncontent-length: 65536\015", 1'b0, hcls_pkg::ST_NONE,
          64'd0},
        '{"G\ncOnTeNt-LeNgTh:\t\t250\n~~\n", 1'b0, hcls_pkg::ST_NONE, 64'd0},
        '{"~\nContent-Lengt@: 3\ncontent-length:1~\n", 1'b0, hcls_pkg::ST_NONE, 64'd0},
        '{"G\ncontent-length: 5\n\ntransfer-encoding\n", 1'b0, hcls_pkg::ST_NONE,
          64'd0},
        '{"G\ncontent-length:", 1'b0, hcls_pkg::ST_NONE, 64'd0}
    };

    // ------------------------------------------------------------------------
    // Random head builder.
    // ------------------------------------------------------------------------
    function automatic void put_text(input string s, input bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
                c = c ^ hcls_pkg::CASE_OFS;
            head_q.push_back(c);
        end
    endfunction

    function automatic void put_blanks(input int n);
        for (int i = 0; i < n; i++)
            head_q.push_back($urandom_range(0, 1) ? hcls_pkg::CH_SPACE : hcls_pkg::CH_TAB);
    endfunction

    function automatic void put_length_line();
        string       digits;
        logic [63:0] v;
        logic [7:0]  tails[3];
        tails = '{hcls_pkg::CH_SPACE, hcls_pkg::CH_TAB, hcls_pkg::CH_CR};
        put_text("content-length", 1'b1);
        if ($urandom_range(0, 19) != 0) head_q.push_back(":");
        else head_q.push_back(8'($urandom_range(0, 255)));
        put_blanks($urandom_range(0, 2));
        case ($urandom_range(0, 9))
            0, 1, 2: digits = $sformatf("%0d", $urandom_range(0, 99999));
            3, 4: digits = (prev_digits.len() > 0) ? prev_digits : "0";
            5, 6: begin
                v = {$urandom, $urandom} >> $urandom_range(0, 63);
                digits = $sformatf("%0d", v);
            end
            // Around the overflow edge: up to ...609 passes, ...610 and up refuse.
            7: digits = {"18446744073709551", $sformatf("%03d", $urandom_range(600, 699))};
            8: digits = {"000", $sformatf("%0d", $urandom_range(0, 99))};
            default: digits = "";
        endcase
        prev_digits = digits;
        put_text(digits, 1'b0);
        repeat ($urandom_range(0, 2)) head_q.push_back(tails[$urandom_range(0, 2)]);
        if ($urandom_range(0, 9) == 0) head_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_random_head();
        int lines;
        head_q.delete();
        prev_digits = "";
        if ($urandom_range(0, 19) == 0) begin
            // Pure noise, any byte values.
            repeat ($urandom_range(1, 12)) head_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 4)) head_q.push_back(8'($urandom_range(33, 126)));
            if ($urandom_range(0, 1)) head_q.push_back(hcls_pkg::CH_CR);
            head_q.push_back(hcls_pkg::CH_LF);
            lines = $urandom_range(0, 3);
            for (int i = 0; i < lines; i++) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7: put_length_line();
                    8, 9: begin
                        if ($urandom_range(0, 3) != 0) put_text("transfer-encoding", 1'b1);
                        else put_text("transfer-encodin", 1'b1);
                        put_text(": chunked", 1'b0);
                    end
                    10, 11, 12, 13, 14, 15, 16:
                        repeat ($urandom_range(1, 10))
                            head_q.push_back(8'($urandom_range(32, 126)));
                    default:
                        repeat ($urandom_range(1, 8))
                            head_q.push_back(8'($urandom_range(0, 255)));
                endcase
                if ($urandom_range(0, 1)) head_q.push_back(hcls_pkg::CH_CR);
                head_q.push_back(hcls_pkg::CH_LF);
            end
            // End on a blank line, on the last LF, or in the middle of a line.
            case ($urandom_range(0, 2))
                0: begin
                    head_q.push_back(hcls_pkg::CH_CR);
                    head_q.push_back(hcls_pkg::CH_LF);
                end
                1: ;
                default: if (head_q.size() > 1) void'(head_q.pop_back());
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // Byte sender: bursts of random length with random gaps between them.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit last, input bit pinned,
                             input hcls_pkg::result_t pinned_res);
        int                gap;
        hcls_pkg::result_t res;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (track_head_byte(b, last, res))
            length_reports_due.push_back(pinned ? pinned_res : res);
    endtask

    task automatic send_head(input bit pinned, input hcls_pkg::result_t pinned_res);
        int n;
        n = head_q.size();
        for (int i = 0; i < n; i++)
            send_byte(head_q[i], i == n - 1, pinned, pinned_res);
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: stalls on a rate that changes from window to window.
    // ------------------------------------------------------------------------
    int ready_pct    = 100;
    int window_left  = 0;
    int ready_rates[4] = '{100, 75, 40, 10};

    always @(negedge aclk) begin
        if (window_left == 0) begin
            ready_pct   = ready_rates[$urandom_range(0, 3)];
            window_left = $urandom_range(20, 120);
        end
        window_left--;
        m_tready <= ($urandom_range(1, 100) <= ready_pct);
    end

    // Check each result transfer against the oldest expected result.
    always @(posedge aclk) begin : result_check
        hcls_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (length_reports_due.size() == 0) begin
                $error("unexpected result transfer: status %0d length %0d",
                       m_tdata[1:0], m_tdata[65:2]);
                error_count++;
            end else begin
                want = length_reports_due.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $error("length_status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                    error_count++;
                end
                if (m_tdata[65:2] !== want.length) begin
                    $error("content_length: expected %0d, got %0d", want.length,
                           m_tdata[65:2]);
                    error_count++;
                end
                if (m_tdata[71:66] !== 6'd0) begin
                    $error("pad: expected 0, got %0h", m_tdata[71:66]);
                    error_count++;
                end
            end
        end
    end

    // Run limit.
    int cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL http_content_length_scanner");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed heads, random heads, drain.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        hcls_pkg::result_t pinned_res;
        logic [7:0]        c;
        int                random_bytes;
        int                random_heads;
        random_bytes = 0;
        random_heads = 0;
        pinned_res   = '0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table.
        for (int k = 0; k < N_CASES; k++) begin
            head_q.delete();
            for (int i = 0; i < head_cases[k].text.len(); i++) begin
                c = head_cases[k].text[i];
                head_q.push_back((c == "~") ? 8'hFF : c);
            end
            pinned_res.status = head_cases[k].status;
            pinned_res.length = head_cases[k].length;
            send_head(head_cases[k].pinned, pinned_res);
        end

        // Random heads until enough bytes and heads have been sent.
        while (random_bytes < RANDOM_BYTES || random_heads < RANDOM_HEADS) begin
            build_random_head();
            random_bytes += head_q.size();
            random_heads++;
            send_head(1'b0, pinned_res);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (length_reports_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("PASS http_content_length_scanner");
        end else begin
            $display("FAIL http_content_length_scanner");
        end
        $finish;
    end

endmodule
